>>> rtl/core/vt4_pkg.sv
// ============================================================================
// vt4_pkg: shared types and constants for the 4x4 vertex transform
// Component, payload and lane-result types, fixed widths, and the reset
// identity pattern for the matrix registers.
// ============================================================================
package vt4_pkg;

    localparam int VT_DIM        = 4;   // vector length and matrix order
    localparam int COMP_W        = 32;  // one Q16.16 component
    localparam int PROD_W        = 2 * COMP_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int TOT_W         = PROD_W + 2;
    localparam int ACC_W         = PROD_W + 3;   // total plus rounding headroom
    localparam int NUM_REGS      = 8;
    localparam int REG_SEL_W     = $clog2(NUM_REGS);
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int LANE_STAGES   = 4;   // products, pair sums, total, round/clip
    localparam int PIPE_STAGES   = LANE_STAGES + 1;   // plus the input register
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic [VT_DIM-1:0][COMP_W-1:0] t_comp4;

    typedef struct packed {
        logic signed [COMP_W-1:0] in_x;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_z;
        logic signed [COMP_W-1:0] in_w;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     saturated;
    } t_vec_out;

    // One row's finished component plus its clip flag.
    typedef struct packed {
        logic signed [COMP_W-1:0] value;
        logic                     sat;
    } t_lane_res;

    typedef t_lane_res [VT_DIM-1:0] t_lane_res4;

    // Identity matrix value of register idx: row = idx/2, column pair = idx%2.
    function automatic logic [CFG_DATA_W-1:0] vt4_ident(input int idx, input int frac_bits);
        int row;
        int grp;
        logic [CFG_DATA_W-1:0] val;
        row = idx / 2;
        grp = idx % 2;
        val = '0;
        if (grp == row / 2) begin
            val = CFG_DATA_W'(1) << (frac_bits + COMP_W * (row % 2));
        end
        return val;
    endfunction

endpackage

>>> rtl/core/vt4_row_lane.sv
// ============================================================================
// vt4_row_lane: one matrix row dotted with the vector
// Four-stage pipeline: 32x32 products, pair sums, total, then round to
// nearest, arithmetic shift and clip to 32 bits.
// ============================================================================
module vt4_row_lane #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_adv,
    input  vt4_pkg::t_comp4    i_vec,
    input  vt4_pkg::t_comp4    i_coef,
    output vt4_pkg::t_lane_res o_res
);
    import vt4_pkg::*;

    localparam logic signed [ACC_W-1:0] L_RND = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] L_MAX = {{(ACC_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] L_MIN = {{(ACC_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod [VT_DIM];
    logic signed [PROD_W-1:0] n_prod [VT_DIM];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic signed [PAIR_W-1:0] n_pair [2];
    logic signed [TOT_W-1:0]  r_tot;
    logic signed [TOT_W-1:0]  n_tot;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_sh;
    t_lane_res                r_res;
    t_lane_res                n_res;

    always_comb begin
        for (int c = 0; c < VT_DIM; c++) begin
            n_prod[c] = $signed(i_vec[c]) * $signed(i_coef[c]);
        end
        for (int p = 0; p < 2; p++) begin
            n_pair[p] = {r_prod[2*p][PROD_W-1], r_prod[2*p]}
                      + {r_prod[2*p+1][PROD_W-1], r_prod[2*p+1]};
        end
        n_tot = {r_pair[0][PAIR_W-1], r_pair[0]} + {r_pair[1][PAIR_W-1], r_pair[1]};

        // round half up, then drop the fraction
        w_rnd = {r_tot[TOT_W-1], r_tot} + L_RND;
        w_sh  = w_rnd >>> FRAC_BITS;
        if (w_sh > L_MAX) begin
            n_res.value = L_MAX[COMP_W-1:0];
            n_res.sat   = 1'b1;
        end else if (w_sh < L_MIN) begin
            n_res.value = L_MIN[COMP_W-1:0];
            n_res.sat   = 1'b1;
        end else begin
            n_res.value = w_sh[COMP_W-1:0];
            n_res.sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_pair <= n_pair;
            r_tot  <= n_tot;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/core/vt4_merge.sv
// ============================================================================
// vt4_merge: lane merge and output buffering
// Packs the four row results into one transaction, ORs the clip flags, and
// holds it in an output register backed by a one-entry skid register.
// ============================================================================
module vt4_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  vt4_pkg::t_lane_res4 i_res,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output vt4_pkg::t_vec_out   o_out_data,
    output logic                o_full
);
    import vt4_pkg::*;

    t_vec_out w_asm;
    t_vec_out r_out;
    t_vec_out r_skid;
    logic     r_out_valid;
    logic     r_skid_valid;
    logic     w_out_fire;

    always_comb begin
        w_asm.out_x     = i_res[0].value;
        w_asm.out_y     = i_res[1].value;
        w_asm.out_z     = i_res[2].value;
        w_asm.out_w     = i_res[3].value;
        w_asm.saturated = i_res[0].sat | i_res[1].sat | i_res[2].sat | i_res[3].sat;
    end

    assign w_out_fire = r_out_valid & ~i_out_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid <= w_asm;
            end else begin
                r_out <= w_asm;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_full      = r_skid_valid;

endmodule

>>> rtl/core/vertex_transform_4x4_unit.sv
// ============================================================================
// vertex_transform_4x4_unit: 4x4 matrix times homogeneous vector, Q16.16
// Four pipelined row lanes sit between the input register and the output register.
// Throughput: one vector per cycle while the output skid register is empty.
// Reset (synchronous, active low): pipeline and output empty, matrix = identity.
// ============================================================================
module vertex_transform_4x4_unit #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // vector input channel
    input  logic                            i_in_valid,
    input  vt4_pkg::t_vec_in                i_in_data,
    output logic                            o_in_stall,
    // result channel
    output logic                            o_out_valid,
    output vt4_pkg::t_vec_out               o_out_data,
    input  logic                            i_out_stall,
    // matrix register writes
    input  logic                            i_cfg_valid,
    input  logic [vt4_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vt4_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_cfg_ready
);
    import vt4_pkg::*;

    // ------------------------------------------------------------------------
    // Matrix registers: two Q16.16 entries each, row-major. Writes are always
    // taken; indexes past the last register are dropped.
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_matrix [NUM_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_matrix[i] <= vt4_ident(i, FRAC_BITS);
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < CFG_IDX_W'(NUM_REGS)) begin
            r_matrix[i_cfg_index[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control. The whole pipe moves as one while the output skid
    // register is empty; a full skid freezes it and stalls the input. The
    // stall therefore comes straight from a register, never from i_out_stall.
    // ------------------------------------------------------------------------
    logic                   w_adv;
    logic                   w_full;
    logic                   w_in_fire;
    logic [PIPE_STAGES-1:0] r_vld;
    t_comp4                 r_vec;
    t_comp4                 n_vec;

    assign w_adv      = ~w_full;
    assign o_in_stall = w_full;
    assign w_in_fire  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], w_in_fire};
        end
    end

    // input register: vector as a column-indexed array for the lanes
    always_comb begin
        n_vec[0] = i_in_data.in_x;
        n_vec[1] = i_in_data.in_y;
        n_vec[2] = i_in_data.in_z;
        n_vec[3] = i_in_data.in_w;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vec <= n_vec;
        end
    end

    // ------------------------------------------------------------------------
    // One lane per matrix row; each sees its row's four coefficients.
    // ------------------------------------------------------------------------
    t_lane_res4 w_res;

    for (genvar r = 0; r < VT_DIM; r++) begin : g_lane
        t_comp4 w_coef;

        assign w_coef[0] = r_matrix[2*r][COMP_W-1:0];
        assign w_coef[1] = r_matrix[2*r][2*COMP_W-1:COMP_W];
        assign w_coef[2] = r_matrix[2*r+1][COMP_W-1:0];
        assign w_coef[3] = r_matrix[2*r+1][2*COMP_W-1:COMP_W];

        vt4_row_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_vec  (r_vec),
            .i_coef (w_coef),
            .o_res  (w_res[r])
        );
    end

    // ------------------------------------------------------------------------
    // Merge the rows into one result transaction and buffer it.
    // ------------------------------------------------------------------------
    vt4_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (r_vld[PIPE_STAGES-1] & w_adv),
        .i_res       (w_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_full      (w_full)
    );

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    // skid only fills behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_out_valid)
        else $error("skid register full while output register empty");

    // skid fills only when the output was held by the receiver
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_full) |-> $past(o_out_valid && i_out_stall))
        else $error("skid register filled without an output stall");

    // a frozen pipe keeps its occupancy
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && $past(i_rst_n)) |=> $stable(r_vld))
        else $error("pipeline moved while frozen");

endmodule
